>>> sv/bafp_pkg.sv
// shared types and constants of the auxiliary field parser
package bafp_pkg;

   // type and subtype characters
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharLowerC = 8'h63;
   localparam logic [7:0] CharUpperC = 8'h43;
   localparam logic [7:0] CharLowerS = 8'h73;
   localparam logic [7:0] CharUpperS = 8'h53;
   localparam logic [7:0] CharLowerI = 8'h69;
   localparam logic [7:0] CharUpperI = 8'h49;
   localparam logic [7:0] CharLowerF = 8'h66;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharUpperH = 8'h48;
   localparam logic [7:0] CharUpperB = 8'h42;

   // parse error codes
   localparam logic [1:0] ErrNone        = 2'd0;
   localparam logic [1:0] ErrUnknownType = 2'd1;
   localparam logic [1:0] ErrTruncated   = 2'd2;

   // element size codes, bytes minus one
   localparam logic [1:0] SizeOne  = 2'd0;
   localparam logic [1:0] SizeTwo  = 2'd1;
   localparam logic [1:0] SizeFour = 2'd3;

   typedef enum logic [2:0] {
      PhTag0  = 3'd0,
      PhTag1  = 3'd1,
      PhType  = 3'd2,
      PhScal  = 3'd3,
      PhStr   = 3'd4,
      PhBsub  = 3'd5,
      PhBcnt  = 3'd6,
      PhBelem = 3'd7
   } phase_type;

   // one classified input byte as it travels through the queue
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_str;    // Z or H
      logic       is_arr;    // B
      logic       scal_ok;   // A or a numeric kind
      logic       sub_ok;    // numeric kind, valid as array subtype
      logic [1:0] size_m1;   // element bytes minus one
      logic       sign_kind; // c, s or i
   } byte_item_type;

endpackage

>>> sv/bafp_front.sv
// front end: accepts request bytes and classifies them for the parser
module bafp_front (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_record_end,
   output logic                   push_valid,
   input  logic                   push_ready,
   output bafp_pkg::byte_item_type push_item
);
   import bafp_pkg::*;

   logic numeric;

   assign req_stall  = !push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_item.data      = req_data_byte;
      push_item.last      = req_record_end;
      push_item.size_m1   = SizeOne;
      push_item.sign_kind = 1'b0;
      numeric             = 1'b1;
      unique case (req_data_byte)
         CharLowerC: begin
            push_item.sign_kind = 1'b1;
         end
         CharUpperC: begin
            push_item.size_m1 = SizeOne;
         end
         CharLowerS: begin
            push_item.size_m1   = SizeTwo;
            push_item.sign_kind = 1'b1;
         end
         CharUpperS: begin
            push_item.size_m1 = SizeTwo;
         end
         CharLowerI: begin
            push_item.size_m1   = SizeFour;
            push_item.sign_kind = 1'b1;
         end
         CharUpperI, CharLowerF: begin
            push_item.size_m1 = SizeFour;
         end
         default: begin
            numeric = 1'b0;
         end
      endcase
      push_item.sub_ok  = numeric;
      push_item.scal_ok = numeric || (req_data_byte == CharUpperA);
      push_item.is_str  = (req_data_byte == CharUpperZ) || (req_data_byte == CharUpperH);
      push_item.is_arr  = (req_data_byte == CharUpperB);
   end

endmodule

>>> sv/bafp_queue.sv
// short queue of classified bytes between front and back
module bafp_queue #(
   parameter int Depth = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_valid,
   output logic                    wr_ready,
   input  bafp_pkg::byte_item_type wr_item,
   output logic                    rd_valid,
   input  logic                    rd_pop,
   output bafp_pkg::byte_item_type rd_item
);
   import bafp_pkg::*;

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

   byte_item_type entries_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic push, pop;

   assign wr_ready = (count_ff != CntFull);
   assign rd_valid = (count_ff != '0);
   assign rd_item  = entries_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

>>> sv/bafp_back.sv
// back end: field parser state machine and registered result stage
module bafp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  bafp_pkg::byte_item_type q_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_tag_first,
   output logic [7:0]              rsp_tag_second,
   output logic [7:0]              rsp_type_code,
   output logic [7:0]              rsp_array_subtype,
   output logic signed [32:0]      rsp_element_value,
   output logic [31:0]             rsp_element_number,
   output logic                    rsp_field_last,
   output logic                    rsp_record_last,
   output logic [1:0]              rsp_parse_error
);
   import bafp_pkg::*;

   phase_type   phase_ff, phase_in, phase_nat;
   logic        skip_ff, skip_in;
   logic [7:0]  tag_first_ff, tag_first_in;
   logic [7:0]  tag_second_ff, tag_second_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sub_ff, sub_in;
   logic [1:0]  pos_ff, pos_in;
   logic [31:0] acc_ff, acc_in, acc_new;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] count_ff, count_in, count_cur;
   logic [1:0]  size_ff, size_in;
   logic        sign_ff, sign_in;

   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_tag_first_ff, out_tag_second_ff, out_type_ff, out_sub_ff;
   logic [32:0] out_value_ff;
   logic [31:0] out_number_ff;
   logic        out_flast_ff, out_rlast_ff;
   logic [1:0]  out_err_ff;

   logic        work;
   logic [1:0]  need_m1;
   logic        gather_done;
   logic        err_unknown, err_trunc;
   logic        sign_bit;
   logic [32:0] ext_mask, ext_value;
   logic        emit;
   logic        flast;
   logic [32:0] value;
   logic [1:0]  err_code;

   assign q_pop = q_valid && (!out_valid_ff || !rsp_stall);
   assign work  = q_pop && !skip_ff;

   assign need_m1     = (phase_ff == PhBcnt) ? SizeFour : size_ff;
   assign gather_done = (pos_ff == need_m1);
   assign acc_new     = (pos_ff == 2'd0) ? {24'd0, q_item.data}
                      : (acc_ff | ({24'd0, q_item.data} << {pos_ff, 3'b000}));

   // sign extension of the gathered element
   always_comb begin
      unique case (size_ff)
         SizeOne: begin
            sign_bit = acc_new[7];
            ext_mask = 33'h0_0000_00FF;
         end
         SizeTwo: begin
            sign_bit = acc_new[15];
            ext_mask = 33'h0_0000_FFFF;
         end
         default: begin
            sign_bit = acc_new[31];
            ext_mask = 33'h0_FFFF_FFFF;
         end
      endcase
      ext_value = {1'b0, acc_new} | ((sign_ff && sign_bit) ? ~ext_mask : 33'd0);
   end

   assign err_unknown = ((phase_ff == PhType) && !(q_item.is_str || q_item.is_arr
                                                    || q_item.scal_ok))
                     || ((phase_ff == PhBsub) && !q_item.sub_ok);
   assign err_trunc   = !err_unknown && q_item.last && (phase_nat != PhTag0);

   // next phase
   always_comb begin
      phase_nat = phase_ff;
      unique case (phase_ff)
         PhTag0: phase_nat = PhTag1;
         PhTag1: phase_nat = PhType;
         PhType: begin
            if (q_item.is_str) begin
               phase_nat = PhStr;
            end else if (q_item.is_arr) begin
               phase_nat = PhBsub;
            end else if (q_item.scal_ok) begin
               phase_nat = PhScal;
            end
         end
         PhScal: phase_nat = gather_done ? PhTag0 : PhScal;
         PhStr:  phase_nat = (q_item.data == 8'd0) ? PhTag0 : PhStr;
         PhBsub: phase_nat = q_item.sub_ok ? PhBcnt : PhBsub;
         PhBcnt: begin
            if (gather_done) begin
               phase_nat = (acc_new == 32'd0) ? PhTag0 : PhBelem;
            end
         end
         PhBelem: begin
            if (gather_done && (remain_ff == 32'd1)) begin
               phase_nat = PhTag0;
            end
         end
         default: phase_nat = phase_ff;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      skip_in  = skip_ff;
      if (q_pop && skip_ff) begin
         if (q_item.last) begin
            skip_in  = 1'b0;
            phase_in = PhTag0;
         end
      end else if (work) begin
         if (err_unknown || err_trunc) begin
            phase_in = PhTag0;
            skip_in  = !q_item.last;
         end else begin
            phase_in = phase_nat;
         end
      end
   end

   // datapath updates and result selection
   always_comb begin
      tag_first_in  = tag_first_ff;
      tag_second_in = tag_second_ff;
      type_in       = type_ff;
      sub_in        = sub_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      remain_in     = remain_ff;
      size_in       = size_ff;
      sign_in       = sign_ff;
      count_cur     = (phase_ff == PhTag0) ? 32'd0 : count_ff;
      emit          = 1'b0;
      flast         = 1'b0;
      value         = 33'd0;
      err_code      = ErrNone;
      if (work) begin
         unique case (phase_ff)
            PhTag0: begin
               tag_first_in  = q_item.data;
               tag_second_in = 8'd0;
               type_in       = 8'd0;
               sub_in        = 8'd0;
               pos_in        = 2'd0;
            end
            PhTag1: begin
               tag_second_in = q_item.data;
            end
            PhType: begin
               type_in = q_item.data;
               pos_in  = 2'd0;
               size_in = q_item.size_m1;
               sign_in = q_item.sign_kind;
            end
            PhBsub: begin
               sub_in  = q_item.data;
               pos_in  = 2'd0;
               size_in = q_item.size_m1;
               sign_in = q_item.sign_kind;
            end
            PhStr: begin
               emit  = 1'b1;
               value = {25'd0, q_item.data};
               flast = (q_item.data == 8'd0);
            end
            default: begin
               // scalar, count or array element: gather little-endian
               acc_in = acc_new;
               pos_in = gather_done ? 2'd0 : pos_ff + 2'd1;
               if (gather_done) begin
                  if (phase_ff == PhBcnt) begin
                     remain_in = acc_new;
                  end else if (phase_ff == PhScal) begin
                     emit  = 1'b1;
                     value = ext_value;
                     flast = 1'b1;
                  end else begin
                     emit      = 1'b1;
                     value     = ext_value;
                     remain_in = remain_ff - 32'd1;
                     flast     = (remain_ff == 32'd1);
                  end
               end
            end
         endcase
         if (err_unknown || err_trunc) begin
            emit     = 1'b1;
            value    = 33'd0;
            flast    = 1'b1;
            pos_in   = 2'd0;
            err_code = err_unknown ? ErrUnknownType : ErrTruncated;
         end
      end
      count_in = count_ff;
      if (work) begin
         count_in = emit ? (flast ? 32'd0 : count_cur + 32'd1) : count_cur;
      end
      out_valid_in = q_pop ? emit : (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PhTag0;
         skip_ff       <= 1'b0;
         tag_first_ff  <= '0;
         tag_second_ff <= '0;
         type_ff       <= '0;
         sub_ff        <= '0;
         pos_ff        <= '0;
         acc_ff        <= '0;
         remain_ff     <= '0;
         count_ff      <= '0;
         size_ff       <= SizeOne;
         sign_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         skip_ff       <= skip_in;
         tag_first_ff  <= tag_first_in;
         tag_second_ff <= tag_second_in;
         type_ff       <= type_in;
         sub_ff        <= sub_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         remain_ff     <= remain_in;
         count_ff      <= count_in;
         size_ff       <= size_in;
         sign_ff       <= sign_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (work && emit) begin
         out_tag_first_ff  <= tag_first_in;
         out_tag_second_ff <= tag_second_in;
         out_type_ff       <= type_in;
         out_sub_ff        <= sub_in;
         out_value_ff      <= value;
         out_number_ff     <= count_cur;
         out_flast_ff      <= flast;
         out_rlast_ff      <= q_item.last;
         out_err_ff        <= err_code;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_tag_first      = out_tag_first_ff;
   assign rsp_tag_second     = out_tag_second_ff;
   assign rsp_type_code      = out_type_ff;
   assign rsp_array_subtype  = out_sub_ff;
   assign rsp_element_value  = out_value_ff;
   assign rsp_element_number = out_number_ff;
   assign rsp_field_last     = out_flast_ff;
   assign rsp_record_last    = out_rlast_ff;
   assign rsp_parse_error    = out_err_ff;

   assert property (@(posedge clock) disable iff (reset)
      skip_ff |-> (phase_ff == PhTag0))
      else $error("skip set outside tag phase");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_err_ff != ErrNone)) |-> out_flast_ff)
      else $error("error result does not close the field");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_err_ff == ErrTruncated)) |-> out_rlast_ff)
      else $error("truncation error without record end");

   assert property (@(posedge clock) disable iff (reset)
      (q_pop && skip_ff) |=> !out_valid_ff || $stable(out_value_ff))
      else $error("skipped byte produced a result");

endmodule

>>> sv/bam_aux_field_parser_core.sv
// top level of the streaming auxiliary field parser
// a request byte is stored in the queue, then the parser registers its result
// throughput: one request byte per cycle unless stalled, set by the parser loop
// a short queue sits between the classifier and the parser, so each side stalls alone
// reset clears the parser state, the queue pointers and the result valid
// after reset the parser expects the first tag character of a new field
module bam_aux_field_parser_core #(
   parameter int QueueDepth = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_record_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_tag_first,
   output logic [7:0]          rsp_tag_second,
   output logic [7:0]          rsp_type_code,
   output logic [7:0]          rsp_array_subtype,
   output logic signed [32:0]  rsp_element_value,
   output logic [31:0]         rsp_element_number,
   output logic                rsp_field_last,
   output logic                rsp_record_last,
   output logic [1:0]          rsp_parse_error
);
   import bafp_pkg::*;

   // classified request entering the queue
   logic          push_valid;
   logic          push_ready;
   byte_item_type push_item;

   // head of the queue seen by the parser
   logic          q_valid;
   logic          q_pop;
   byte_item_type q_item;

   // front: decode type and subtype characters up front
   bafp_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_record_end (req_record_end),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   // decoupling queue, request side stalls only when it is full
   bafp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_item  (push_item),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_item  (q_item)
   );

   // back: field state machine, element gathering and result register
   bafp_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_pop              (q_pop),
      .q_item             (q_item),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tag_first      (rsp_tag_first),
      .rsp_tag_second     (rsp_tag_second),
      .rsp_type_code      (rsp_type_code),
      .rsp_array_subtype  (rsp_array_subtype),
      .rsp_element_value  (rsp_element_value),
      .rsp_element_number (rsp_element_number),
      .rsp_field_last     (rsp_field_last),
      .rsp_record_last    (rsp_record_last),
      .rsp_parse_error    (rsp_parse_error)
   );

endmodule

>>> tb/testbench.sv
// self-checking testbench for the streaming auxiliary field parser
module testbench;
   import bafp_pkg::*;

   // one result element, in port order
   typedef struct packed {
      logic [7:0]  tag_first;
      logic [7:0]  tag_second;
      logic [7:0]  type_code;
      logic [7:0]  array_subtype;
      logic [32:0] element_value;
      logic [31:0] element_number;
      logic        field_last;
      logic        record_last;
      logic [1:0]  parse_error;
   } aux_element_type;

   // one request byte; checked rows carry a hand-written element
   typedef struct packed {
      logic [7:0]      data;
      logic            last;
      logic            checked;
      aux_element_type want;
   } aux_row_type;

   localparam int DirectedRows = 28;
   localparam int FeedTarget   = 740;
   localparam int CycleLimit   = 60000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_data_byte = 8'h00;
   logic                req_record_end = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_tag_first;
   logic [7:0]          rsp_tag_second;
   logic [7:0]          rsp_type_code;
   logic [7:0]          rsp_array_subtype;
   logic signed [32:0]  rsp_element_value;
   logic [31:0]         rsp_element_number;
   logic                rsp_field_last;
   logic                rsp_record_last;
   logic [1:0]          rsp_parse_error;

   bam_aux_field_parser_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_record_end     (req_record_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_tag_first      (rsp_tag_first),
      .rsp_tag_second     (rsp_tag_second),
      .rsp_type_code      (rsp_type_code),
      .rsp_array_subtype  (rsp_array_subtype),
      .rsp_element_value  (rsp_element_value),
      .rsp_element_number (rsp_element_number),
      .rsp_field_last     (rsp_field_last),
      .rsp_record_last    (rsp_record_last),
      .rsp_parse_error    (rsp_parse_error)
   );

   always #6 clock = ~clock;

   // request bytes still to be sent, and elements still owed by the parser
   aux_row_type     byte_feed[$];
   aux_element_type pending_elements[$];
   aux_row_type     directed_rows[DirectedRows];
   logic [7:0]      rec_bytes[$];

   aux_row_type     on_wire;
   aux_element_type seen_element;
   aux_element_type owed_element;
   aux_element_type parsed_element;
   int              mismatch_count = 0;
   int              responses_seen = 0;
   int              bytes_accepted = 0;
   int              cycle_count = 0;
   bit              calm;

   // parser mirror state
   phase_type   phase_now;
   logic [7:0]  tag_hi, tag_lo, kind_held, sub_held;
   logic [1:0]  byte_idx;
   logic [31:0] acc, left_count, elem_idx;
   bit          skipping;

   // bytes per element of a numeric kind, zero for anything else
   function automatic int kind_bytes(input logic [7:0] k);
      case (k)
         CharLowerC, CharUpperC: return 1;
         CharLowerS, CharUpperS: return 2;
         CharLowerI, CharUpperI, CharLowerF: return 4;
         default: return 0;
      endcase
   endfunction

   // little-endian gather into acc; true once n bytes are in
   function automatic bit collect_byte(input logic [7:0] b, input int n);
      int p;
      p = byte_idx;
      if (p == 0) acc = {24'h0, b};
      else acc = acc | ({24'h0, b} << (8 * p));
      if (p + 1 >= n) begin
         byte_idx = 2'd0;
         return 1'b1;
      end
      byte_idx = 2'(p + 1);
      return 1'b0;
   endfunction

   // sign-extend the signed kinds to 33 bits, zero-extend the rest
   function automatic logic [32:0] widen_element(input logic [31:0] a, input logic [7:0] k);
      case (k)
         CharLowerC: return {{25{a[7]}}, a[7:0]};
         CharLowerS: return {{17{a[15]}}, a[15:0]};
         CharLowerI: return {a[31], a};
         default:    return {1'b0, a};
      endcase
   endfunction

   function automatic void clear_parser();
      phase_now  = PhTag0;
      tag_hi     = '0;
      tag_lo     = '0;
      kind_held  = '0;
      sub_held   = '0;
      byte_idx   = '0;
      acc        = '0;
      left_count = '0;
      elem_idx   = '0;
      skipping   = 1'b0;
   endfunction

   // advance the mirror by one request byte; true when it yields an element
   function automatic bit parse_aux_byte(input logic [7:0] b, input logic last,
                                         output aux_element_type res);
      bit          emit;
      logic [1:0]  err;
      logic        fl;
      logic [32:0] val;
      int          n;
      emit = 1'b0;
      err  = ErrNone;
      fl   = 1'b0;
      val  = '0;
      res  = '0;
      if (skipping) begin
         if (last) begin
            skipping  = 1'b0;
            phase_now = PhTag0;
         end
         return 1'b0;
      end
      case (phase_now)
         PhTag0: begin
            tag_hi    = b;
            tag_lo    = '0;
            kind_held = '0;
            sub_held  = '0;
            elem_idx  = '0;
            byte_idx  = '0;
            phase_now = PhTag1;
         end
         PhTag1: begin
            tag_lo    = b;
            phase_now = PhType;
         end
         PhType: begin
            kind_held = b;
            byte_idx  = '0;
            if (b == CharUpperZ || b == CharUpperH) phase_now = PhStr;
            else if (b == CharUpperB) phase_now = PhBsub;
            else if (b == CharUpperA || kind_bytes(b) != 0) phase_now = PhScal;
            else err = ErrUnknownType;
         end
         PhScal: begin
            n = (kind_held == CharUpperA) ? 1 : kind_bytes(kind_held);
            if (n == 0) n = 1;
            if (collect_byte(b, n)) begin
               emit      = 1'b1;
               val       = widen_element(acc, kind_held);
               fl        = 1'b1;
               phase_now = PhTag0;
            end
         end
         PhStr: begin
            emit = 1'b1;
            val  = {25'h0, b};
            if (b == 8'h00) begin
               fl        = 1'b1;
               phase_now = PhTag0;
            end
         end
         PhBsub: begin
            sub_held = b;
            byte_idx = '0;
            if (kind_bytes(b) == 0) err = ErrUnknownType;
            else phase_now = PhBcnt;
         end
         PhBcnt: begin
            if (collect_byte(b, 4)) begin
               left_count = acc;
               phase_now  = (left_count != 0) ? PhBelem : PhTag0;
            end
         end
         default: begin
            n = kind_bytes(sub_held);
            if (n == 0) n = 1;
            if (collect_byte(b, n)) begin
               emit       = 1'b1;
               val        = widen_element(acc, sub_held);
               left_count = left_count - 1;
               if (left_count == 0) begin
                  fl        = 1'b1;
                  phase_now = PhTag0;
               end
            end
         end
      endcase
      // record ended with the field still open
      if (err == ErrNone && last && phase_now != PhTag0) err = ErrTruncated;
      if (err != ErrNone) begin
         emit      = 1'b1;
         val       = '0;
         fl        = 1'b1;
         phase_now = PhTag0;
         byte_idx  = '0;
         skipping  = !last;
      end
      if (!emit) return 1'b0;
      res.tag_first      = tag_hi;
      res.tag_second     = tag_lo;
      res.type_code      = kind_held;
      res.array_subtype  = sub_held;
      res.element_value  = val;
      res.element_number = elem_idx;
      res.field_last     = fl;
      res.record_last    = last;
      res.parse_error    = err;
      elem_idx = fl ? 32'd0 : elem_idx + 1;
      return 1'b1;
   endfunction

   function automatic aux_row_type row_plain(input logic [7:0] d, input logic l);
      aux_row_type r;
      r      = '0;
      r.data = d;
      r.last = l;
      return r;
   endfunction

   function automatic aux_row_type row_checked(input logic [7:0] d, input logic l,
         input logic [7:0] t1, input logic [7:0] t2, input logic [7:0] ty,
         input logic [7:0] sub, input logic [32:0] val, input logic [31:0] num,
         input logic fl, input logic rl, input logic [1:0] err);
      aux_row_type r;
      r         = row_plain(d, l);
      r.checked = 1'b1;
      r.want    = {t1, t2, ty, sub, val, num, fl, rl, err};
      return r;
   endfunction

   // type byte: mostly the eleven known kinds, sometimes any byte
   function automatic logic [7:0] pick_kind();
      case ($urandom_range(11))
         0:  return CharUpperA;
         1:  return CharLowerC;
         2:  return CharUpperC;
         3:  return CharLowerS;
         4:  return CharUpperS;
         5:  return CharLowerI;
         6:  return CharUpperI;
         7:  return CharLowerF;
         8:  return CharUpperZ;
         9:  return CharUpperH;
         10: return CharUpperB;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] pick_subtype();
      case ($urandom_range(7))
         0: return CharLowerC;
         1: return CharUpperC;
         2: return CharLowerS;
         3: return CharUpperS;
         4: return CharLowerI;
         5: return CharUpperI;
         6: return CharLowerF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // append one field with random content to rec_bytes, not always well-formed
   task automatic add_field();
      int         n;
      int         cnt;
      logic [7:0] kind;
      logic [7:0] sub;
      rec_bytes.push_back(8'($urandom_range(255)));
      rec_bytes.push_back(8'($urandom_range(255)));
      kind = pick_kind();
      rec_bytes.push_back(kind);
      if (kind == CharUpperZ || kind == CharUpperH) begin
         n = $urandom_range(5);
         repeat (n) rec_bytes.push_back(8'($urandom_range(1, 255)));
         rec_bytes.push_back(8'h00);
      end else if (kind == CharUpperB) begin
         sub = pick_subtype();
         rec_bytes.push_back(sub);
         if (kind_bytes(sub) == 0) begin
            repeat ($urandom_range(3)) rec_bytes.push_back(8'($urandom_range(255)));
         end else if ($urandom_range(19) == 0) begin
            // huge count, the record end cuts the array short
            repeat (4) rec_bytes.push_back(8'($urandom_range(255)));
            repeat ($urandom_range(6)) rec_bytes.push_back(8'($urandom_range(255)));
         end else begin
            cnt = ($urandom_range(6) == 0) ? 0 : $urandom_range(1, 4);
            rec_bytes.push_back(8'(cnt));
            repeat (3) rec_bytes.push_back(8'h00);
            repeat (cnt * kind_bytes(sub)) rec_bytes.push_back(8'($urandom_range(255)));
         end
      end else if (kind == CharUpperA) begin
         rec_bytes.push_back(8'($urandom_range(255)));
      end else if (kind_bytes(kind) != 0) begin
         repeat (kind_bytes(kind)) rec_bytes.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(3)) rec_bytes.push_back(8'($urandom_range(255)));
      end
   endtask

   // random records: mostly whole fields, some cut short, some plain noise
   task automatic build_records();
      int  n;
      int  cut;
      bit  noise;
      while (byte_feed.size() < FeedTarget) begin
         rec_bytes.delete();
         noise = ($urandom_range(9) == 0);
         if (noise) begin
            n = $urandom_range(1, 8);
            repeat (n) rec_bytes.push_back(8'($urandom_range(255)));
         end else begin
            n = $urandom_range(1, 3);
            repeat (n) add_field();
            if ($urandom_range(6) == 0 && rec_bytes.size() > 1) begin
               cut = $urandom_range(1, rec_bytes.size() - 1);
               while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
            end
         end
         for (int i = 0; i < rec_bytes.size(); i++) begin
            byte_feed.push_back(row_plain(rec_bytes[i], (i == rec_bytes.size() - 1) ||
                                          (noise && $urandom_range(7) == 0)));
         end
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 100)
         $display("mismatch on response %0d, %s: got %h, expected %h",
                  responses_seen, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_element(input aux_element_type got, input aux_element_type want);
      if (got.tag_first !== want.tag_first)
         report_mismatch("tag_first", 64'(got.tag_first), 64'(want.tag_first));
      if (got.tag_second !== want.tag_second)
         report_mismatch("tag_second", 64'(got.tag_second), 64'(want.tag_second));
      if (got.type_code !== want.type_code)
         report_mismatch("type_code", 64'(got.type_code), 64'(want.type_code));
      if (got.array_subtype !== want.array_subtype)
         report_mismatch("array_subtype", 64'(got.array_subtype), 64'(want.array_subtype));
      if (got.element_value !== want.element_value)
         report_mismatch("element_value", 64'(got.element_value), 64'(want.element_value));
      if (got.element_number !== want.element_number)
         report_mismatch("element_number", 64'(got.element_number),
                         64'(want.element_number));
      if (got.field_last !== want.field_last)
         report_mismatch("field_last", 64'(got.field_last), 64'(want.field_last));
      if (got.record_last !== want.record_last)
         report_mismatch("record_last", 64'(got.record_last), 64'(want.record_last));
      if (got.parse_error !== want.parse_error)
         report_mismatch("parse_error", 64'(got.parse_error), 64'(want.parse_error));
   endtask

   // a quiet window in the random part where neither side idles
   always_comb calm = (bytes_accepted >= 350) && (bytes_accepted < 500);

   // both handshakes; responses are checked before the new request is predicted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         // response side: compare against the oldest owed element
         if (rsp_valid && !rsp_stall) begin
            seen_element = {rsp_tag_first, rsp_tag_second, rsp_type_code, rsp_array_subtype,
                            rsp_element_value, rsp_element_number, rsp_field_last,
                            rsp_record_last, rsp_parse_error};
            if (pending_elements.size() == 0) begin
               report_mismatch("response with nothing pending", 64'(seen_element), 64'h0);
            end else begin
               owed_element = pending_elements.pop_front();
               check_element(seen_element, owed_element);
            end
            responses_seen++;
         end
         rsp_stall <= !calm && ($urandom_range(99) < 26);

         // request side: an accepted byte steps the mirror
         if (req_valid && !req_stall) begin
            if (parse_aux_byte(on_wire.data, on_wire.last, parsed_element))
               pending_elements.push_back(on_wire.checked ? on_wire.want : parsed_element);
            else if (on_wire.checked)
               pending_elements.push_back(on_wire.want);
            bytes_accepted++;
         end
         // a stalled request holds; otherwise present the next byte or idle
         if (!req_valid || !req_stall) begin
            if (byte_feed.size() != 0 && (calm || $urandom_range(99) >= 26)) begin
               on_wire = byte_feed.pop_front();
               req_valid      <= 1'b1;
               req_data_byte  <= on_wire.data;
               req_record_end <= on_wire.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CycleLimit) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      clear_parser();
      // directed rows: extremes, unknown type with skip, empty array,
      // truncation after one tag character, and a string ending its record
      directed_rows = '{
         row_plain("X", 1'b0),
         row_plain("A", 1'b0),
         row_plain(CharLowerC, 1'b0),
         // most negative 8-bit value, sign-extended
         row_checked(8'h80, 1'b0, "X", "A", CharLowerC, 8'h00, 33'h1_FFFF_FF80, 32'd0,
                     1'b1, 1'b0, ErrNone),
         row_plain("Y", 1'b0),
         row_plain("B", 1'b0),
         row_plain(CharUpperI, 1'b0),
         row_plain(8'hFF, 1'b0),
         row_plain(8'hFF, 1'b0),
         row_plain(8'hFF, 1'b0),
         // largest unsigned 32-bit value, no sign extension
         row_checked(8'hFF, 1'b0, "Y", "B", CharUpperI, 8'h00, 33'h0_FFFF_FFFF, 32'd0,
                     1'b1, 1'b0, ErrNone),
         row_plain("Z", 1'b0),
         row_plain("Z", 1'b0),
         // unknown type, rest of the record skipped
         row_checked("q", 1'b0, "Z", "Z", "q", 8'h00, 33'h0, 32'd0,
                     1'b1, 1'b0, ErrUnknownType),
         row_plain(8'h00, 1'b1),
         // empty array closes the record cleanly
         row_plain("B", 1'b0),
         row_plain("B", 1'b0),
         row_plain(CharUpperB, 1'b0),
         row_plain(CharUpperC, 1'b0),
         row_plain(8'h00, 1'b0),
         row_plain(8'h00, 1'b0),
         row_plain(8'h00, 1'b0),
         row_plain(8'h00, 1'b1),
         // record ends after one tag character
         row_checked("Q", 1'b1, "Q", 8'h00, 8'h00, 8'h00, 33'h0, 32'd0,
                     1'b1, 1'b1, ErrTruncated),
         row_plain("S", 1'b0),
         row_plain("T", 1'b0),
         row_plain(CharUpperZ, 1'b0),
         // empty string: only the terminator, which also ends the record
         row_checked(8'h00, 1'b1, "S", "T", CharUpperZ, 8'h00, 33'h0, 32'd0,
                     1'b1, 1'b1, ErrNone)
      };
      foreach (directed_rows[i]) byte_feed.push_back(directed_rows[i]);
      build_records();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // every request taken, every element delivered, then a short drain
      while (byte_feed.size() != 0 || req_valid) @(posedge clock);
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
